// ----- rtl/ppmrb_pkg.sv -----
// Shared types and constants of the point to polar min range binner.
`timescale 1ns / 1ps
package ppmrb_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_CHECK,
      ST_DIV,
      ST_IDX,
      ST_PT_CMP,
      ST_FILL,
      ST_BIN_OUT,
      ST_DONE
   } state_type;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_POINT = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [3:0] STAT_STORED     = 4'd0;
   localparam logic [3:0] STAT_NOT_CLOSER = 4'd1;
   localparam logic [3:0] STAT_HEIGHT     = 4'd2;
   localparam logic [3:0] STAT_RANGE      = 4'd3;
   localparam logic [3:0] STAT_ANGLE      = 4'd4;
   localparam logic [3:0] STAT_INDEX      = 4'd5;
   localparam logic [3:0] STAT_READ_OK    = 4'd6;
   localparam logic [3:0] STAT_READ_BAD   = 4'd7;
   localparam logic [3:0] STAT_CLEARED    = 4'd8;

   localparam logic [2:0] CSR_ANGLE_LOWEST   = 3'd0;
   localparam logic [2:0] CSR_ANGLE_HIGHEST  = 3'd1;
   localparam logic [2:0] CSR_ANGLE_STEP     = 3'd2;
   localparam logic [2:0] CSR_RANGE_LOWEST   = 3'd3;
   localparam logic [2:0] CSR_RANGE_HIGHEST  = 3'd4;
   localparam logic [2:0] CSR_HEIGHT_LOWEST  = 3'd5;
   localparam logic [2:0] CSR_HEIGHT_HIGHEST = 3'd6;
   localparam logic [2:0] CSR_EMPTY_FILL     = 3'd7;

   localparam logic signed [19:0] PI_Q      = 20'sd205887;
   localparam logic signed [19:0] HALF_PI_Q = 20'sd102944;
   localparam logic [30:0] INV_GAIN_Q31     = 31'd1304065748;
   localparam int DIV_W                     = 20;
   localparam int ATAN_LEN                  = 24;

   // arctan(2^-i) in Q16.16, rounded to nearest
   localparam logic [16:0] ATAN_Q16 [ATAN_LEN] = '{
      17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
      17'd1024, 17'd512, 17'd256, 17'd128, 17'd64, 17'd32,
      17'd16, 17'd8, 17'd4, 17'd2, 17'd1, 17'd0,
      17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
   };

endpackage

// ----- rtl/point_to_polar_min_range_binner.sv -----
// Top level of the point to polar min range binner.
`timescale 1ns / 1ps
// Usage:
//  req_* stream: one item per transfer; req_tuser selects clear, add point
//  or read bin. rsp_* stream: one result item per request item, in order.
//  csr_* port: register writes, taken at any cycle, meant only while idle.
// Processing steps (from accept to result registered):
//  add point : CORDIC vectoring loop, two-part range multiply, 20-step
//              restoring divide for the bin index, one bin memory read
//              and compare; rejected heights go straight to the result.
//  read bin  : one registered memory read.
//  clear     : bin count divide, then one bin written per cycle over the
//              whole memory.
//  One item is worked on at a time; req_tready is high only when idle.
// The result sits in an output register, so the next item is taken while
// it waits; a low rsp_tready stalls the block at its next result.
// Reset sets the CSR registers to defaults and the scan to zero bins; bins
// hold no meaningful data until the first clear.
module point_to_polar_min_range_binner
   import ppmrb_pkg::*;
#(
   parameter int MAX_BINS     = 1024,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // coord_x, coord_y, coord_z, read_index, zero pad
   input  logic [111:0] req_tdata,
   // op, point_valid
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // bin_number, bin_range, bins_in_use, zero pad
   output logic [63:0]  rsp_tdata,
   // status
   output logic [3:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   state_type state_ff, state_in;

   logic signed [18:0] amin_ff, amax_ff;
   logic [17:0]        astep_ff;
   logic [31:0]        rlo_ff, rhi_ff, fill_val_ff;
   logic signed [31:0] hlo_ff, hhi_ff;

   logic [1:0]         op_ff, op_in;
   logic               origin_ff, origin_in;
   logic signed [34:0] x_ff, x_in, y_ff, y_in;
   logic signed [19:0] z_ff, z_in;
   logic [IW-1:0]      iter_ff, iter_in;
   logic [65:0]        acc_ff, acc_in;
   logic [31:0]        range_ff, range_in;
   logic [18:0]        rem_ff, rem_in, den_ff, den_in;
   logic [19:0]        quo_ff, quo_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic [AW-1:0]      fill_ff, fill_in;
   logic [12:0]        active_ff, active_in;
   logic [3:0]         res_status_ff, res_status_in;
   logic [11:0]        res_bin_ff, res_bin_in;
   logic [31:0]        res_range_ff, res_range_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_status_ff, rsp_status_in;
   logic [11:0]        rsp_bin_ff, rsp_bin_in;
   logic [31:0]        rsp_range_ff, rsp_range_in;
   logic [12:0]        rsp_active_ff, rsp_active_in;

   logic [31:0]        mem [MAX_BINS];
   logic [31:0]        rd_data_ff;
   logic               mem_rd, mem_wr;
   logic [AW-1:0]      mem_rd_addr, mem_wr_addr;
   logic [31:0]        mem_wr_data;

   // request fields
   logic [1:0]         in_op;
   logic               in_pv;
   logic signed [31:0] in_x, in_y, in_z;
   logic [11:0]        in_ri;

   logic [17:0]        step_eff;
   logic signed [20:0] span, clr_num;
   logic signed [34:0] px, py, x_sh, y_sh;
   logic [33:0]        xc;
   logic [16:0]        mul_a;
   logic [47:0]        mul_p;
   logic [34:0]        prod;
   logic [31:0]        rng;
   logic signed [19:0] zc, amin_w, amax_w;
   logic signed [20:0] d_ang;
   logic [20:0]        trial;
   logic [19:0]        quo_next;
   logic [12:0]        clr_bins;

   assign in_op = req_tuser[1:0];
   assign in_pv = req_tuser[2];
   assign in_x  = req_tdata[31:0];
   assign in_y  = req_tdata[63:32];
   assign in_z  = req_tdata[95:64];
   assign in_ri = req_tdata[107:96];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_active_ff, rsp_range_ff, rsp_bin_ff};

   assign step_eff = (astep_ff == 18'd0) ? 18'd1 : astep_ff;
   assign span     = 21'(amax_ff) - 21'(amin_ff);
   assign clr_num  = span + 21'($signed({1'b0, step_eff})) - 21'sd1;
   assign amin_w   = 20'(amin_ff);
   assign amax_w   = 20'(amax_ff);

   assign px = 35'(in_x);
   assign py = 35'(in_y);

   assign x_sh = x_ff >>> iter_ff;
   assign y_sh = y_ff >>> iter_ff;

   // range scaling: x * (1/K) split into two 17-bit halves of x
   assign xc    = x_ff[34] ? 34'd0 : x_ff[33:0];
   assign mul_a = (state_ff == ST_MUL_HI) ? xc[33:17] : xc[16:0];
   assign mul_p = mul_a * INV_GAIN_Q31;
   assign prod  = acc_ff[65:31];
   assign rng   = (|prod[34:32]) ? 32'hFFFF_FFFF : prod[31:0];

   always_comb begin
      if (origin_ff) begin
         zc = 20'sd0;
      end else if (z_ff > PI_Q) begin
         zc = PI_Q;
      end else if (z_ff < -PI_Q) begin
         zc = -PI_Q;
      end else begin
         zc = z_ff;
      end
   end
   assign d_ang = 21'(zc) - 21'(amin_w);

   // restoring divide, one quotient bit per cycle
   assign trial    = {1'b0, rem_ff, quo_ff[19]} - {2'b0, den_ff};
   assign quo_next = {quo_ff[18:0], ~trial[20]};
   assign clr_bins = (span <= 21'sd0) ? 13'd0 :
                     (quo_next > 20'(MAX_BINS)) ? 13'(MAX_BINS) : quo_next[12:0];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      origin_in     = origin_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      iter_in       = iter_ff;
      acc_in        = acc_ff;
      range_in      = range_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      den_in        = den_ff;
      dcnt_in       = dcnt_ff;
      fill_in       = fill_ff;
      active_in     = active_ff;
      res_status_in = res_status_ff;
      res_bin_in    = res_bin_ff;
      res_range_in  = res_range_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_bin_in    = rsp_bin_ff;
      rsp_range_in  = rsp_range_ff;
      rsp_active_in = rsp_active_ff;
      mem_rd        = 1'b0;
      mem_rd_addr   = quo_ff[AW-1:0];
      mem_wr        = 1'b0;
      mem_wr_addr   = quo_ff[AW-1:0];
      mem_wr_data   = range_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in        = in_op;
               res_bin_in   = 12'd0;
               res_range_in = 32'd0;
               case (in_op)
                  OP_CLEAR: begin
                     rem_in   = 19'd0;
                     quo_in   = clr_num[19:0];
                     den_in   = {1'b0, step_eff};
                     dcnt_in  = 5'd0;
                     state_in = ST_DIV;
                  end
                  OP_POINT: begin
                     if (!in_pv || in_z > hhi_ff || in_z < hlo_ff) begin
                        res_status_in = STAT_HEIGHT;
                        state_in      = ST_DONE;
                     end else begin
                        origin_in = (in_x == 32'sd0) && (in_y == 32'sd0);
                        iter_in   = '0;
                        if (px < 0) begin
                           if (py >= 0) begin
                              x_in = py;
                              y_in = -px;
                              z_in = HALF_PI_Q;
                           end else begin
                              x_in = -py;
                              y_in = px;
                              z_in = -HALF_PI_Q;
                           end
                        end else begin
                           x_in = px;
                           y_in = py;
                           z_in = 20'sd0;
                        end
                        state_in = ST_CORDIC;
                     end
                  end
                  OP_READ: begin
                     res_bin_in = in_ri;
                     if ({1'b0, in_ri} < active_ff) begin
                        mem_rd        = 1'b1;
                        mem_rd_addr   = AW'(in_ri);
                        res_status_in = STAT_READ_OK;
                        state_in      = ST_BIN_OUT;
                     end else begin
                        res_status_in = STAT_READ_BAD;
                        state_in      = ST_DONE;
                     end
                  end
                  default: begin
                     res_status_in = STAT_READ_BAD;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end
         ST_CORDIC: begin
            if (y_ff < 0) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - 20'($signed({1'b0, ATAN_Q16[5'(iter_ff)]}));
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + 20'($signed({1'b0, ATAN_Q16[5'(iter_ff)]}));
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IW'(CORDIC_STEPS - 1)) begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            acc_in   = 66'(mul_p) + (66'd1 << 30);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = acc_ff + (66'(mul_p) << 17);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            range_in = rng;
            if (rng < rlo_ff || rng > rhi_ff) begin
               res_status_in = STAT_RANGE;
               state_in      = ST_DONE;
            end else if (zc < amin_w || zc > amax_w) begin
               res_status_in = STAT_ANGLE;
               state_in      = ST_DONE;
            end else begin
               // round to nearest: (2d + s) / 2s
               rem_in   = 19'd0;
               quo_in   = {d_ang[18:0], 1'b0} + {2'd0, step_eff};
               den_in   = {step_eff, 1'b0};
               dcnt_in  = 5'd0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = trial[20] ? {rem_ff[17:0], quo_ff[19]} : trial[18:0];
            quo_in  = quo_next;
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'(DIV_W - 1)) begin
               if (op_ff == OP_CLEAR) begin
                  active_in = clr_bins;
                  fill_in   = '0;
                  state_in  = ST_FILL;
               end else begin
                  state_in = ST_IDX;
               end
            end
         end
         ST_IDX: begin
            if (quo_ff >= 20'(active_ff)) begin
               res_status_in = STAT_INDEX;
               state_in      = ST_DONE;
            end else begin
               mem_rd     = 1'b1;
               res_bin_in = 12'(quo_ff);
               state_in   = ST_PT_CMP;
            end
         end
         ST_PT_CMP: begin
            if (range_ff < rd_data_ff) begin
               mem_wr        = 1'b1;
               res_status_in = STAT_STORED;
               res_range_in  = range_ff;
            end else begin
               res_status_in = STAT_NOT_CLOSER;
               res_range_in  = rd_data_ff;
            end
            state_in = ST_DONE;
         end
         ST_FILL: begin
            mem_wr      = 1'b1;
            mem_wr_addr = fill_ff;
            mem_wr_data = fill_val_ff;
            fill_in     = fill_ff + 1'b1;
            if (fill_ff == AW'(MAX_BINS - 1)) begin
               res_status_in = STAT_CLEARED;
               state_in      = ST_DONE;
            end
         end
         ST_BIN_OUT: begin
            res_range_in = rd_data_ff;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_bin_in    = res_bin_ff;
               rsp_range_in  = res_range_ff;
               rsp_active_in = active_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 13'd0;
         rsp_valid_ff <= 1'b0;
         amin_ff      <= -19'sd205887;
         amax_ff      <= 19'sd205887;
         astep_ff     <= 18'd1144;
         rlo_ff       <= 32'd0;
         rhi_ff       <= 32'hFFFF_FFFF;
         hlo_ff       <= 32'sh8000_0000;
         hhi_ff       <= 32'sh7FFF_FFFF;
         fill_val_ff  <= 32'hFFFF_FFFF;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_ANGLE_LOWEST:   amin_ff     <= csr_data[18:0];
               CSR_ANGLE_HIGHEST:  amax_ff     <= csr_data[18:0];
               CSR_ANGLE_STEP:     astep_ff    <= csr_data[17:0];
               CSR_RANGE_LOWEST:   rlo_ff      <= csr_data;
               CSR_RANGE_HIGHEST:  rhi_ff      <= csr_data;
               CSR_HEIGHT_LOWEST:  hlo_ff      <= csr_data;
               CSR_HEIGHT_HIGHEST: hhi_ff      <= csr_data;
               CSR_EMPTY_FILL:     fill_val_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      origin_ff     <= origin_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      iter_ff       <= iter_in;
      acc_ff        <= acc_in;
      range_ff      <= range_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      den_ff        <= den_in;
      dcnt_ff       <= dcnt_in;
      fill_ff       <= fill_in;
      res_status_ff <= res_status_in;
      res_bin_ff    <= res_bin_in;
      res_range_ff  <= res_range_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_range_ff  <= rsp_range_in;
      rsp_active_ff <= rsp_active_in;
   end

   // bin memory, registered read
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

endmodule

// ----- rtl/ppmrb_checker.sv -----
// Port-level checks of the binner and their binding to the top level.
`timescale 1ns / 1ps
module ppmrb_checker
   import ppmrb_pkg::*;
#(
   parameter int MAX_BINS = 1024
) (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata,
   input logic [3:0]   rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while busy");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_HEIGHT || rsp_tuser == STAT_RANGE ||
                     rsp_tuser == STAT_ANGLE || rsp_tuser == STAT_INDEX ||
                     rsp_tuser == STAT_CLEARED) |-> rsp_tdata[43:0] == 44'd0)
      else $error("rejected item carries bin data");

   a_bins_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[56:44] <= 13'(MAX_BINS))
      else $error("bin count above limit");

endmodule

bind point_to_polar_min_range_binner ppmrb_checker #(.MAX_BINS(MAX_BINS)) u_ppmrb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
